// ===== hdl/cdia_pkg.sv =====
package cdia_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int COORD_W     = 64;
    localparam int ID_W        = 9;

    localparam logic [COORD_W-1:0] ABS_MASK     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [COORD_W-1:0] EXP_ALL_ONES = 64'h7FF0_0000_0000_0000;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_pair;

    function automatic logic [ID_W-1:0] to_id(input logic [CNT_W-1:0] v);
        logic [CNT_W+ID_W-1:0] ext;
        ext = {{ID_W{1'b0}}, v};
        return ext[ID_W-1:0];
    endfunction

endpackage

// ===== hdl/cdia_if.sv =====
interface cdia_in_if import cdia_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;

    modport source(output valid, coord_x, coord_y, input ready);
    modport sink(input valid, coord_x, coord_y, output ready);
endinterface

interface cdia_out_if import cdia_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] node_id;
    logic            is_new;
    logic            table_full;

    modport source(output valid, node_id, is_new, table_full, input ready);
    modport sink(input valid, node_id, is_new, table_full, output ready);
endinterface

// ===== hdl/coordinate_dedup_id_assign.sv =====
// channel  direction  payload                          transfer when
// i_in     in         coord_x[63:0], coord_y[63:0]     valid && ready
// o_out    out        node_id[8:0], is_new, table_full valid && ready
//
// On a hit at entry k the scan ends after entry k; on a miss it covers every stored
// entry before the pair is stored, or refused when the table is full:
// the scan reads one stored pair per cycle through the single table read port
// and the shared pair compare, then stops at the first match.
// Reset is synchronous, active low; it clears the entry count, no table clear.
// i_in.ready is high only while idle; a result waits in the output register
// and the next item is accepted meanwhile.
module coordinate_dedup_id_assign import cdia_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cdia_in_if.sink    i_in,
    cdia_out_if.source o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_MISS = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    t_pair mem [TABLE_DEPTH];

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic             r_issue_done, n_issue_done;
    logic             r_rd_vld, n_rd_vld;
    logic             r_rd_last, n_rd_last;
    logic [ADDR_W-1:0] r_rd_idx;
    t_pair            r_rd_data;
    t_pair            r_key, n_key;
    logic [ID_W-1:0]  r_res_id, n_res_id;
    logic             r_res_new, n_res_new;
    logic             r_res_full, n_res_full;
    logic             r_out_valid, n_out_valid;
    logic [ID_W-1:0]  r_out_id, n_out_id;
    logic             r_out_new, n_out_new;
    logic             r_out_full, n_out_full;

    logic w_rd_en;
    logic w_we;
    logic w_match;
    logic w_in_xfer;
    logic w_last_addr;

    cdia_pair_eq u_eq (
        .i_a     (r_rd_data),
        .i_b     (r_key),
        .o_match (w_match)
    );

    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_last_addr = ({1'b0, r_addr} + 1'b1) == r_count;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_addr       = r_addr;
        n_issue_done = r_issue_done;
        n_rd_vld     = 1'b0;
        n_rd_last    = 1'b0;
        n_key        = r_key;
        n_res_id     = r_res_id;
        n_res_new    = r_res_new;
        n_res_full   = r_res_full;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_id     = r_out_id;
        n_out_new    = r_out_new;
        n_out_full   = r_out_full;
        w_rd_en      = 1'b0;
        w_we         = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_key.x      = i_in.coord_x;
                    n_key.y      = i_in.coord_y;
                    n_addr       = '0;
                    n_issue_done = 1'b0;
                    n_state      = (r_count == '0) ? S_MISS : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rd_vld && w_match) begin
                    n_res_id   = to_id({1'b0, r_rd_idx} + 1'b1);
                    n_res_new  = 1'b0;
                    n_res_full = 1'b0;
                    n_state    = S_EMIT;
                end else if (r_rd_vld && r_rd_last) begin
                    n_state = S_MISS;
                end else if (!r_issue_done) begin
                    w_rd_en      = 1'b1;
                    n_rd_vld     = 1'b1;
                    n_rd_last    = w_last_addr;
                    n_issue_done = w_last_addr;
                    n_addr       = r_addr + 1'b1;
                end
            end
            S_MISS: begin
                if (r_count == CNT_W'(TABLE_DEPTH)) begin
                    n_res_id   = '0;
                    n_res_new  = 1'b0;
                    n_res_full = 1'b1;
                end else begin
                    w_we       = 1'b1;
                    n_count    = r_count + 1'b1;
                    n_res_id   = to_id(r_count + 1'b1);
                    n_res_new  = 1'b1;
                    n_res_full = 1'b0;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_id    = r_res_id;
                    n_out_new   = r_res_new;
                    n_out_full  = r_res_full;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_count[ADDR_W-1:0]] <= r_key;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[r_addr];
            r_rd_idx  <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_rd_last    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_addr       <= n_addr;
            r_issue_done <= n_issue_done;
            r_rd_vld     <= n_rd_vld;
            r_rd_last    <= n_rd_last;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_res_id   <= n_res_id;
        r_res_new  <= n_res_new;
        r_res_full <= n_res_full;
        r_out_id   <= n_out_id;
        r_out_new  <= n_out_new;
        r_out_full <= n_out_full;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.node_id    = r_out_id;
    assign o_out.is_new     = r_out_new;
    assign o_out.table_full = r_out_full;

endmodule

// ===== hdl/cdia_pair_eq.sv =====
module cdia_pair_eq import cdia_pkg::*; (
    input  t_pair i_a,
    input  t_pair i_b,
    output logic  o_match
);

    function automatic logic dbl_eq(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
        logic nan_a;
        logic nan_b;
        logic zeros;
        nan_a = (a & ABS_MASK) > EXP_ALL_ONES;
        nan_b = (b & ABS_MASK) > EXP_ALL_ONES;
        zeros = ((a & ABS_MASK) == '0) && ((b & ABS_MASK) == '0);
        return !nan_a && !nan_b && (zeros || (a == b));
    endfunction

    assign o_match = dbl_eq(i_a.x, i_b.x) && dbl_eq(i_a.y, i_b.y);

endmodule

// ===== tb/coordinate_dedup_id_assign_tb.sv =====
`timescale 1ns / 100ps

module coordinate_dedup_id_assign_tb;
    import cdia_pkg::*;

    localparam logic [COORD_W-1:0] POS_ZERO   = 64'h0000_0000_0000_0000;
    localparam logic [COORD_W-1:0] NEG_ZERO   = 64'h8000_0000_0000_0000;
    localparam logic [COORD_W-1:0] POS_INF    = 64'h7FF0_0000_0000_0000;
    localparam logic [COORD_W-1:0] NEG_INF    = 64'hFFF0_0000_0000_0000;
    localparam logic [COORD_W-1:0] QUIET_NAN  = 64'h7FF8_0000_0000_0000;
    localparam logic [COORD_W-1:0] SIGNAL_NAN = 64'h7FF0_0000_0000_0001;
    localparam logic [COORD_W-1:0] NEG_NAN    = 64'hFFF8_0000_0000_0000;
    localparam logic [COORD_W-1:0] MAX_FINITE = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [COORD_W-1:0] MIN_DENORM = 64'h0000_0000_0000_0001;
    localparam logic [COORD_W-1:0] ONE        = 64'h3FF0_0000_0000_0000;
    localparam logic [COORD_W-1:0] NEG_ONE    = 64'hBFF0_0000_0000_0000;
    localparam logic [COORD_W-1:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int NUM_SPECIALS = 12;

    localparam int RANDOM_PAIRS = 1600;
    localparam int DRAIN_EVERY  = 400;
    localparam int MAX_REPORTS  = 10;

    typedef enum int {PICK_HIT, PICK_NEAR_MISS, PICK_SPECIAL, PICK_RANDOM} pick_t;

    typedef struct packed {
        logic [ID_W-1:0] node_id;
        logic            is_new;
        logic            table_full;
    } id_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cdia_in_if  pair_ch();
    cdia_out_if id_ch();

    coordinate_dedup_id_assign dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (pair_ch),
        .o_out  (id_ch)
    );

    always #5 i_clk = ~i_clk;

    logic [COORD_W-1:0] known_x [TABLE_DEPTH];
    logic [COORD_W-1:0] known_y [TABLE_DEPTH];
    int                 known_count = 0;

    id_result_t expected_ids[$];

    int burst_left    = 0;
    int mismatches    = 0;
    int unexpected    = 0;
    int checked       = 0;
    int pairs_sent    = 0;
    int stored_hits   = 0;
    int full_misses   = 0;

    function automatic bit coord_is_nan(input logic [COORD_W-1:0] v);
        return (v & ABS_MASK) > EXP_ALL_ONES;
    endfunction

    function automatic bit coord_equal(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
        if (coord_is_nan(a) || coord_is_nan(b))
            return 1'b0;
        if (((a & ABS_MASK) == '0) && ((b & ABS_MASK) == '0))
            return 1'b1;
        return a == b;
    endfunction

    function automatic id_result_t lookup_or_store(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
        id_result_t r;
        int         found;
        found = -1;
        for (int i = 0; i < known_count && found < 0; i++) begin
            if (coord_equal(known_x[i], x) && coord_equal(known_y[i], y))
                found = i;
        end
        if (found >= 0) begin
            r.node_id    = ID_W'(found + 1);
            r.is_new     = 1'b0;
            r.table_full = 1'b0;
            stored_hits++;
        end else if (known_count >= TABLE_DEPTH) begin
            r.node_id    = '0;
            r.is_new     = 1'b0;
            r.table_full = 1'b1;
            full_misses++;
        end else begin
            known_x[known_count] = x;
            known_y[known_count] = y;
            known_count++;
            r.node_id    = ID_W'(known_count);
            r.is_new     = 1'b1;
            r.table_full = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] special_coord(input int sel);
        case (sel)
            0:       return POS_ZERO;
            1:       return NEG_ZERO;
            2:       return POS_INF;
            3:       return NEG_INF;
            4:       return QUIET_NAN;
            5:       return SIGNAL_NAN;
            6:       return NEG_NAN;
            7:       return MAX_FINITE;
            8:       return MIN_DENORM;
            9:       return ONE;
            10:      return NEG_ONE;
            default: return ALL_ONES;
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] random_coord();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [COORD_W-1:0] flip_zero_sign(input logic [COORD_W-1:0] v);
        if ((v & ABS_MASK) == '0 && $urandom_range(0, 1) == 1)
            return v ^ NEG_ZERO;
        return v;
    endfunction

    task automatic send_pair(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        if (burst_left <= 0) begin
            pair_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        pair_ch.valid   <= 1'b1;
        pair_ch.coord_x <= x;
        pair_ch.coord_y <= y;
        do @(posedge i_clk); while (!pair_ch.ready);
        expected_ids.push_back(lookup_or_store(x, y));
        pairs_sent++;
        burst_left--;
    endtask

    task automatic wait_all_results();
        pair_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (expected_ids.size() != 0);
    endtask

    task automatic test_special_values();
        send_pair(POS_ZERO, POS_ZERO);
        send_pair(NEG_ZERO, POS_ZERO);
        send_pair(NEG_ZERO, NEG_ZERO);
        send_pair(POS_ZERO, NEG_ZERO);
        send_pair(QUIET_NAN, ONE);
        send_pair(QUIET_NAN, ONE);
        send_pair(ONE, NEG_NAN);
        send_pair(SIGNAL_NAN, SIGNAL_NAN);
        send_pair(ALL_ONES, ALL_ONES);
        send_pair(POS_INF, NEG_INF);
        send_pair(POS_INF, NEG_INF);
        send_pair(NEG_INF, POS_INF);
        send_pair(MAX_FINITE, MIN_DENORM);
        send_pair(MIN_DENORM, MAX_FINITE);
        send_pair(MAX_FINITE, MIN_DENORM);
        send_pair(ONE, ONE);
        send_pair(NEG_ONE, ONE);
        send_pair(ONE, ONE);
        send_pair(NEG_ZERO, POS_ZERO);
        send_pair(ONE, NEG_ZERO);
        send_pair(ONE, POS_ZERO);
        wait_all_results();
    endtask

    task automatic test_random_pairs();
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        pick_t              pick;
        int                 roll;
        int                 idx;
        int                 bit_pos;
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                pick = PICK_HIT;
            else if (roll < 65)
                pick = PICK_NEAR_MISS;
            else if (roll < 75)
                pick = PICK_SPECIAL;
            else
                pick = PICK_RANDOM;
            if (known_count == 0 && (pick == PICK_HIT || pick == PICK_NEAR_MISS))
                pick = PICK_RANDOM;
            case (pick)
                PICK_HIT: begin
                    idx = $urandom_range(0, known_count - 1);
                    x   = flip_zero_sign(known_x[idx]);
                    y   = flip_zero_sign(known_y[idx]);
                end
                PICK_NEAR_MISS: begin
                    idx     = $urandom_range(0, known_count - 1);
                    bit_pos = $urandom_range(0, COORD_W - 1);
                    x       = known_x[idx];
                    y       = known_y[idx];
                    if ($urandom_range(0, 1) == 1)
                        x[bit_pos] = ~x[bit_pos];
                    else
                        y[bit_pos] = ~y[bit_pos];
                end
                PICK_SPECIAL: begin
                    x = special_coord($urandom_range(0, NUM_SPECIALS - 1));
                    y = ($urandom_range(0, 1) == 1) ? special_coord($urandom_range(0, NUM_SPECIALS - 1))
                                                    : random_coord();
                    if ($urandom_range(0, 1) == 1) begin
                        x = y;
                        y = special_coord($urandom_range(0, NUM_SPECIALS - 1));
                    end
                end
                default: begin
                    x = random_coord();
                    y = random_coord();
                end
            endcase
            send_pair(x, y);
            if ((n + 1) % DRAIN_EVERY == 0)
                wait_all_results();
        end
        wait_all_results();
    endtask

    task automatic test_table_full();
        while (known_count < TABLE_DEPTH)
            send_pair(random_coord(), random_coord());
        send_pair(random_coord(), random_coord());
        send_pair(QUIET_NAN, QUIET_NAN);
        send_pair(known_x[TABLE_DEPTH-1], known_y[TABLE_DEPTH-1]);
        send_pair(known_x[0], known_y[0]);
        send_pair(random_coord(), random_coord());
        send_pair(known_x[TABLE_DEPTH-1], known_y[TABLE_DEPTH-1]);
        send_pair(known_x[TABLE_DEPTH/2], known_y[TABLE_DEPTH/2]);
        wait_all_results();
    endtask

    initial begin
        id_ch.ready <= 1'b0;
        forever begin
            int stall_left;
            int rx_cycle;
            @(posedge i_clk);
            rx_cycle++;
            if (stall_left > 0) begin
                id_ch.ready <= 1'b0;
                stall_left--;
            end else if ((rx_cycle % 900) >= 300 && $urandom_range(0, 3) == 0) begin
                id_ch.ready <= 1'b0;
                stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                          : $urandom_range(0, 8);
            end else begin
                id_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        id_result_t want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && id_ch.valid && id_ch.ready) begin
                if (expected_ids.size() == 0) begin
                    unexpected++;
                    if (mismatches + unexpected <= MAX_REPORTS)
                        $display("unexpected result: node_id=%0d is_new=%0b table_full=%0b",
                                 id_ch.node_id, id_ch.is_new, id_ch.table_full);
                end else begin
                    want = expected_ids.pop_front();
                    checked++;
                    if (id_ch.node_id !== want.node_id || id_ch.is_new !== want.is_new ||
                        id_ch.table_full !== want.table_full) begin
                        mismatches++;
                        if (mismatches + unexpected <= MAX_REPORTS)
                            $display("result %0d: expected id=%0d new=%0b full=%0b, got id=%0d new=%0b full=%0b",
                                     checked, want.node_id, want.is_new, want.table_full,
                                     id_ch.node_id, id_ch.is_new, id_ch.table_full);
                    end
                end
            end
        end
    end

    initial begin
        #25_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n         <= 1'b0;
        pair_ch.valid   <= 1'b0;
        pair_ch.coord_x <= '0;
        pair_ch.coord_y <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_values();
        test_random_pairs();
        test_table_full();

        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
        $display("%0d pairs sent, %0d stored, %0d found again, %0d refused with the table full",
                 pairs_sent, known_count, stored_hits, full_misses);
        $display("%0d results checked, %0d mismatches, %0d unexpected",
                 checked, mismatches, unexpected);
        if (mismatches == 0 && unexpected == 0 && expected_ids.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
